/* rtl/text_glyph_frame_renderer_top_assert.svh */
// assertion macros shared by the renderer checker
`ifndef TEXT_GLYPH_FRAME_RENDERER_TOP_ASSERT_SVH
`define TEXT_GLYPH_FRAME_RENDERER_TOP_ASSERT_SVH
// property that must hold in the cycle after the trigger
`define TGF_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);
// property that must hold in the same cycle as the trigger
`define TGF_ASSERT_NOW(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);
`endif

/* rtl/tgfr_pkg.sv */
// shared types, constants and font rom for the glyph frame renderer
`timescale 1ns / 1ps
package tgfr_pkg;
    localparam int DisplayWidthDef = 128;
    localparam int PageCountDef    = 8;

    localparam logic [1:0] CmdSetCursor = 2'd0;
    localparam logic [1:0] CmdPutChar   = 2'd1;
    localparam logic [1:0] CmdFill      = 2'd2;
    localparam logic [1:0] CmdRead      = 2'd3;

    localparam logic [7:0] CodeNewline  = 8'h0A;
    localparam logic [7:0] CodeFirst    = 8'h20;
    localparam logic [7:0] CodeLast     = 8'h7E;
    localparam logic [7:0] CodeQuestion = 8'h3F;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] column;
        logic [7:0] page_in;
        logic [7:0] char_code;
        logic [7:0] fill_value;
        logic       reset_cursor;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] cursor_column;
        logic [3:0] cursor_page;
        logic       dropped;
    } t_out;

    // 5x7 font, one row of five column bytes per glyph index, byte chosen by column
    function automatic logic [7:0] font_byte(input logic [6:0] g, input logic [2:0] c);
        logic [39:0] row;
        unique case (g)
            7'd0:  row = 40'h0000000000; 7'd1:  row = 40'h00005F0000;
            7'd2:  row = 40'h0007000700; 7'd3:  row = 40'h147F147F14;
            7'd4:  row = 40'h242A7F2A12; 7'd5:  row = 40'h2313086462;
            7'd6:  row = 40'h3649552250; 7'd7:  row = 40'h0005030000;
            7'd8:  row = 40'h001C224100; 7'd9:  row = 40'h0041221C00;
            7'd10: row = 40'h14083E0814; 7'd11: row = 40'h08083E0808;
            7'd12: row = 40'h0050300000; 7'd13: row = 40'h0808080808;
            7'd14: row = 40'h0060600000; 7'd15: row = 40'h2010080402;
            7'd16: row = 40'h3E5149453E; 7'd17: row = 40'h00427F4000;
            7'd18: row = 40'h4261514946; 7'd19: row = 40'h2141454B31;
            7'd20: row = 40'h1814127F10; 7'd21: row = 40'h2745454539;
            7'd22: row = 40'h3C4A494930; 7'd23: row = 40'h0171090503;
            7'd24: row = 40'h3649494936; 7'd25: row = 40'h064949291E;
            7'd26: row = 40'h0036360000; 7'd27: row = 40'h0056360000;
            7'd28: row = 40'h0814224100; 7'd29: row = 40'h1414141414;
            7'd30: row = 40'h0041221408; 7'd31: row = 40'h0201510906;
            7'd32: row = 40'h324979413E; 7'd33: row = 40'h7E1111117E;
            7'd34: row = 40'h7F49494936; 7'd35: row = 40'h3E41414122;
            7'd36: row = 40'h7F4141221C; 7'd37: row = 40'h7F49494941;
            7'd38: row = 40'h7F09090901; 7'd39: row = 40'h3E4149497A;
            7'd40: row = 40'h7F0808087F; 7'd41: row = 40'h00417F4100;
            7'd42: row = 40'h2040413F01; 7'd43: row = 40'h7F08142241;
            7'd44: row = 40'h7F40404040; 7'd45: row = 40'h7F020C027F;
            7'd46: row = 40'h7F0408107F; 7'd47: row = 40'h3E4141413E;
            7'd48: row = 40'h7F09090906; 7'd49: row = 40'h3E4151215E;
            7'd50: row = 40'h7F09192946; 7'd51: row = 40'h4649494931;
            7'd52: row = 40'h01017F0101; 7'd53: row = 40'h3F4040403F;
            7'd54: row = 40'h1F2040201F; 7'd55: row = 40'h7F2018207F;
            7'd56: row = 40'h6314081463; 7'd57: row = 40'h0304780403;
            7'd58: row = 40'h6151494543; 7'd59: row = 40'h007F414100;
            7'd60: row = 40'h0204081020; 7'd61: row = 40'h0041417F00;
            7'd62: row = 40'h0402010204; 7'd63: row = 40'h4040404040;
            7'd64: row = 40'h0001020400; 7'd65: row = 40'h2054545478;
            7'd66: row = 40'h7F48444438; 7'd67: row = 40'h3844444420;
            7'd68: row = 40'h384444487F; 7'd69: row = 40'h3854545418;
            7'd70: row = 40'h087E090102; 7'd71: row = 40'h0C5252523E;
            7'd72: row = 40'h7F08040478; 7'd73: row = 40'h00447D4000;
            7'd74: row = 40'h2040443D00; 7'd75: row = 40'h7F10284400;
            7'd76: row = 40'h00417F4000; 7'd77: row = 40'h7C04180478;
            7'd78: row = 40'h7C08040478; 7'd79: row = 40'h3844444438;
            7'd80: row = 40'h7C14141408; 7'd81: row = 40'h081414187C;
            7'd82: row = 40'h7C08040408; 7'd83: row = 40'h4854545420;
            7'd84: row = 40'h043F444020; 7'd85: row = 40'h3C4040207C;
            7'd86: row = 40'h1C2040201C; 7'd87: row = 40'h3C4030403C;
            7'd88: row = 40'h4428102844; 7'd89: row = 40'h0C5050503C;
            7'd90: row = 40'h4464544C44; 7'd91: row = 40'h0008364100;
            7'd92: row = 40'h00007F0000; 7'd93: row = 40'h0041360800;
            7'd94: row = 40'h08082A1C08;
            default: row = 40'h0201510906;
        endcase
        unique case (c)
            3'd0: font_byte = row[39:32];
            3'd1: font_byte = row[31:24];
            3'd2: font_byte = row[23:16];
            3'd3: font_byte = row[15:8];
            3'd4: font_byte = row[7:0];
            default: font_byte = 8'h00;
        endcase
    endfunction
endpackage

/* rtl/text_glyph_frame_renderer_top.sv */
// top level of the glyph frame renderer: sequencer, cursor and frame store
`timescale 1ns / 1ps
// Usage of the text glyph frame renderer.
// Commands enter on i_start with the t_in payload on i_cmd; a command is
// taken when i_start is high and o_busy is low. Each command gives one
// result on o_result, marked by o_done for exactly one cycle.
// Steps: set cursor, newline and dropped characters go straight to done;
// read: ram address, registered read, capture, done; put character: six
// column writes, then done; fill writes every store entry
// (DISPLAY_WIDTH * PAGE_COUNT), then done. The single ram write port
// serialises the put character and fill writes. One command at a time:
// o_busy is high from acceptance until the cycle before o_done, so the
// next command can be taken in the done cycle.
// After reset the block runs a clearing pass with o_busy high, writing
// zero to every store entry and giving no result; the cursor is at
// column 0, page 0.
// The receiver cannot stall: o_done and o_result are valid for one cycle.
module text_glyph_frame_renderer_top #(
    parameter int DISPLAY_WIDTH = tgfr_pkg::DisplayWidthDef,
    parameter int PAGE_COUNT    = tgfr_pkg::PageCountDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tgfr_pkg::t_in  i_cmd,
    output logic           o_busy,
    output logic           o_done,
    output tgfr_pkg::t_out o_result
);
    import tgfr_pkg::*;

    localparam int StoreSize = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int AddrW = (StoreSize > 1) ? $clog2(StoreSize) : 1;
    localparam int ColW  = $clog2(DISPLAY_WIDTH + 1);
    localparam int PgW   = $clog2(PAGE_COUNT + 1);
    localparam int AW1   = AddrW + 1;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StClear = 3'd1;
    localparam logic [2:0] StDraw  = 3'd2;
    localparam logic [2:0] StRead  = 3'd3;
    localparam logic [2:0] StRdat  = 3'd4;
    localparam logic [2:0] StDone  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [ColW-1:0]  r_col, n_col;
    logic [PgW-1:0]   r_pg, n_pg;
    logic [AddrW-1:0] r_addr, n_addr;
    logic [AW1-1:0]   r_cnt, n_cnt;
    logic [7:0]       r_wval, n_wval;
    logic [6:0]       r_glyph, n_glyph;
    logic [7:0]       r_rd, n_rd;
    logic             r_drop, n_drop;
    logic             r_rvalid, n_rvalid;
    logic             r_done, n_done;
    logic             r_init, n_init;

    logic             ram_we;
    logic [7:0]       ram_wdata, ram_rdata;

    // input decode
    logic             acc, rd_ok;
    logic [ColW-1:0]  wcol;
    logic [PgW-1:0]   wpg;
    logic [7:0]       code;
    logic [ColW+3:0]  col_sum;
    logic [AW1+8:0]   rd_addr, dr_addr;

    assign acc   = i_start && (r_state == StIdle);
    assign rd_ok = ({24'd0, i_cmd.column} < 32'(DISPLAY_WIDTH)) &&
                   ({24'd0, i_cmd.page_in} < 32'(PAGE_COUNT));
    assign code  = ((i_cmd.char_code < CodeFirst) || (i_cmd.char_code > CodeLast)) ?
                   CodeQuestion : i_cmd.char_code;
    assign rd_addr = (AW1+9)'(i_cmd.page_in) * (AW1+9)'(DISPLAY_WIDTH)
                     + (AW1+9)'(i_cmd.column);

    // cursor after any wrap for put character
    always_comb begin
        col_sum = (ColW+4)'(r_col) + (ColW+4)'(6);
        if (col_sum > (ColW+4)'(DISPLAY_WIDTH)) begin
            wcol = '0;
            wpg  = (32'(r_pg) < 32'(PAGE_COUNT)) ? r_pg + 1'b1 : r_pg;
        end else begin
            wcol = r_col;
            wpg  = r_pg;
        end
        dr_addr = (AW1+9)'(wpg) * (AW1+9)'(DISPLAY_WIDTH) + (AW1+9)'(wcol);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_pg     = r_pg;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_wval   = r_wval;
        n_glyph  = r_glyph;
        n_rd     = r_rd;
        n_drop   = r_drop;
        n_rvalid = r_rvalid;
        n_init   = r_init;
        n_done   = 1'b0;
        ram_we   = 1'b0;
        ram_wdata = r_wval;
        unique case (r_state)
            StIdle: begin
                if (acc) begin
                    n_rd   = 8'h00;
                    n_drop = 1'b0;
                    unique case (i_cmd.command)
                        CmdSetCursor: begin
                            n_col = ({24'd0, i_cmd.column} < 32'(DISPLAY_WIDTH)) ?
                                    ColW'(i_cmd.column) : '0;
                            n_pg  = ({24'd0, i_cmd.page_in} < 32'(PAGE_COUNT)) ?
                                    PgW'(i_cmd.page_in) : '0;
                            n_state = StDone;
                        end
                        CmdPutChar: begin
                            if (i_cmd.char_code == CodeNewline) begin
                                n_col = '0;
                                n_pg  = (32'(r_pg) < 32'(PAGE_COUNT)) ? r_pg + 1'b1 : r_pg;
                                n_state = StDone;
                            end else if (32'(wpg) >= 32'(PAGE_COUNT)) begin
                                n_col  = wcol;
                                n_pg   = wpg;
                                n_drop = 1'b1;
                                n_state = StDone;
                            end else begin
                                n_col   = wcol;
                                n_pg    = wpg;
                                n_addr  = AddrW'(dr_addr);
                                n_cnt   = '0;
                                n_glyph = 7'(code - CodeFirst);
                                n_state = StDraw;
                            end
                        end
                        CmdFill: begin
                            n_wval = i_cmd.fill_value;
                            n_addr = '0;
                            n_cnt  = '0;
                            if (i_cmd.reset_cursor) begin
                                n_col = '0;
                                n_pg  = '0;
                            end
                            n_state = StClear;
                        end
                        default: begin
                            n_rvalid = rd_ok;
                            n_addr   = AddrW'(rd_addr);
                            n_state  = StRead;
                        end
                    endcase
                end
            end
            StClear: begin
                // one store entry per cycle, no result for the pass after reset
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (32'(r_cnt) == StoreSize - 1) begin
                    n_state = r_init ? StIdle : StDone;
                    n_init  = 1'b0;
                end
            end
            StDraw: begin
                // five glyph columns then one blank, clipped at store end
                ram_wdata = (r_cnt < AW1'(5)) ? font_byte(r_glyph, r_cnt[2:0]) : 8'h00;
                ram_we = (32'(r_addr) + 32'(r_cnt) < StoreSize) &&
                         (32'(r_cnt) < 6) ? 1'b1 : 1'b0;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == AW1'(5)) begin
                    n_col   = r_col + ColW'(6);
                    n_state = StDone;
                end
            end
            StRead: begin
                n_state = StRdat;
            end
            StRdat: begin
                n_rd    = r_rvalid ? ram_rdata : 8'h00;
                n_state = StDone;
            end
            StDone: begin
                n_done  = 1'b1;
                n_state = StIdle;
            end
            default: n_state = StIdle;
        endcase
    end

    // state and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StClear;
            r_col    <= '0;
            r_pg     <= '0;
            r_addr   <= '0;
            r_cnt    <= '0;
            r_wval   <= 8'h00;
            r_done   <= 1'b0;
            r_drop   <= 1'b0;
            r_rvalid <= 1'b0;
            r_init   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_pg     <= n_pg;
            r_addr   <= n_addr;
            r_cnt    <= n_cnt;
            r_wval   <= n_wval;
            r_done   <= n_done;
            r_drop   <= n_drop;
            r_rvalid <= n_rvalid;
            r_init   <= n_init;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph;
        r_rd    <= n_rd;
    end

    // draw address walks with the column counter; clear steps r_addr itself
    logic [AddrW-1:0] ram_addr;
    assign ram_addr = (r_state == StDraw) ? AddrW'(32'(r_addr) + 32'(r_cnt)) : r_addr;

    tgfr_ram #(.Width(8), .Depth(StoreSize)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_busy = (r_state != StIdle);
    assign o_done = r_done;
    assign o_result.read_data     = r_rd;
    assign o_result.cursor_column = 8'(r_col);
    assign o_result.cursor_page   = 4'(r_pg);
    assign o_result.dropped       = r_drop;
endmodule

/* rtl/tgfr_ram.sv */
// generic single port ram with registered read
`timescale 1ns / 1ps
module tgfr_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/tgfr_checker.sv */
// port level checks for the glyph frame renderer
`timescale 1ns / 1ps
`include "text_glyph_frame_renderer_top_assert.svh"
module tgfr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input logic           o_done,
    input tgfr_pkg::t_out o_result
);
    // an accepted command makes the block busy
    `TGF_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy, "not busy")
    // a result strobe lasts one cycle
    `TGF_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "done held")
    // the block is idle while a result is shown
    `TGF_ASSERT_NOW(a_idle_at_done, i_clk, i_rst_n, o_done, !o_busy, "busy at done")
    // dropped is never shown with the cursor on the first page
    `TGF_ASSERT_NOW(a_drop_page, i_clk, i_rst_n, o_done && o_result.dropped, o_result.cursor_page != 4'd0, "drop on first page")
endmodule

bind text_glyph_frame_renderer_top tgfr_checker u_tgfr_checker (.*);
